// ----- hdl/pcl_pkg.sv -----
// Package for the positional byte list: sizes, opcode and result codes,
// state encoding and the control word broadcast along the cell row.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pcl_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CHAR_W   = 8;
  localparam int POS_W    = 8;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_DELETE = 2'd1,
    OP_GET    = 2'd2,
    OP_PRINT  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_ELEM    = 2'd0,
    KIND_INVALID = 2'd1,
    KIND_FULL    = 2'd2,
    KIND_END     = 2'd3
  } kind_t;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_PRINT = 1'b1
  } state_t;

  // Control word seen by every cell in the row.
  typedef struct packed {
    logic              ins;
    logic              del;
    logic [IDX_W-1:0]  idx;
    logic [CHAR_W-1:0] data;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- hdl/positional_char_list.sv -----
// Top level of the positional byte list: row of shifting cells, list
// controller, read selector and output register.
// Depends on pcl_pkg and pcl_cell.
//
//   Channel  Handshake              Payload
//   -------  ---------------------  ------------------------------------
//   input    in_valid / in_stall    opcode, position, char_in
//   output   out_valid / out_stall  result_kind, char_out, last
//
// Add and delete complete in the cycle of the transaction: every cell moves
// in parallel with its neighbour, so the whole list row updates together.
// Get sends its byte straight into the output register.
// Print sends one byte per cycle through the read selector while the output
// is not stalled, then the end marker; the input is stalled during the print.
// Any stall on the output holds the current result and pauses the print.
// Reset (synchronous, active high) empties the list and the output register;
// the cell contents are not cleared, as entries beyond count are never read.
`timescale 1ns / 1ps
`default_nettype none

module positional_char_list
  import pcl_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        opcode,
  input  wire logic [POS_W-1:0]  position,
  input  wire logic [CHAR_W-1:0] char_in,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [1:0]             result_kind,
  output logic [CHAR_W-1:0]      char_out,
  output logic                   last
);

  state_t            state;
  state_t            state_next;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  prt_idx;
  cell_ctrl_t        ctrl;
  logic [CHAR_W-1:0] cell_q [CAPACITY];
  logic [CHAR_W-1:0] rd_data;
  logic [IDX_W-1:0]  rd_sel;
  logic [IDX_W-1:0]  idx_in;
  op_t               op;
  logic              accept;
  logic              out_free;
  logic              full;
  logic              add_ok;
  logic              rd_ok;
  logic              out_load;
  kind_t             kind_next;
  logic [CHAR_W-1:0] char_next;
  logic              last_next;
  logic [POS_W:0]    pos_ext;
  logic [POS_W:0]    cnt_ext;

  assign op       = op_t'(opcode);
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;

  // Position checks, done on widened values so count + 1 cannot wrap.
  assign pos_ext = {1'b0, position};
  assign cnt_ext = (POS_W + 1)'(count);
  assign full    = (count == CNT_W'(CAPACITY));
  assign add_ok  = !full && (position != '0) && (pos_ext <= cnt_ext + 1'b1);
  assign rd_ok   = (position != '0) && (pos_ext <= cnt_ext);
  assign idx_in  = IDX_W'(position - POS_W'(1));

  // Row of cells; the ends see zero from outside the row.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [CHAR_W-1:0] left_d;
    logic [CHAR_W-1:0] right_d;
    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_inner_l
      assign left_d = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_end
      assign right_d = '0;
    end else begin : g_inner_r
      assign right_d = cell_q[i+1];
    end
    pcl_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .cell_idx (IDX_W'(i)),
      .left_q   (left_d),
      .right_q  (right_d),
      .q        (cell_q[i])
    );
  end

  // Single read port across the row, shared by get and print.
  assign rd_sel  = (state == ST_PRINT) ? prt_idx[IDX_W-1:0] : idx_in;
  assign rd_data = cell_q[rd_sel];

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (op == OP_PRINT)) begin
          state_next = ST_PRINT;
        end
      end
      ST_PRINT: begin
        if (out_free && (prt_idx == count)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Controller outputs: cell row control and the result to be registered.
  always_comb begin
    ctrl      = '{ins: 1'b0, del: 1'b0, idx: idx_in, data: char_in};
    out_load  = 1'b0;
    kind_next = KIND_ELEM;
    char_next = '0;
    last_next = 1'b1;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (op)
            OP_ADD: begin
              if (full) begin
                out_load  = 1'b1;
                kind_next = KIND_FULL;
              end else if (!add_ok) begin
                out_load  = 1'b1;
                kind_next = KIND_INVALID;
              end else begin
                ctrl.ins = 1'b1;
              end
            end
            OP_DELETE: begin
              if (rd_ok) begin
                ctrl.del = 1'b1;
              end else begin
                out_load  = 1'b1;
                kind_next = KIND_INVALID;
              end
            end
            OP_GET: begin
              out_load = 1'b1;
              if (rd_ok) begin
                kind_next = KIND_ELEM;
                char_next = rd_data;
              end else begin
                kind_next = KIND_INVALID;
              end
            end
            OP_PRINT: begin
              out_load = 1'b0;
            end
            default: out_load = 1'b0;
          endcase
        end
      end
      ST_PRINT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (prt_idx < count) begin
            kind_next = KIND_ELEM;
            char_next = rd_data;
            last_next = 1'b0;
          end else begin
            kind_next = KIND_END;
          end
        end
      end
      default: out_load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      prt_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctrl.ins) begin
        count <= count + 1'b1;
      end else if (ctrl.del) begin
        count <= count - 1'b1;
      end
      if (state == ST_IDLE) begin
        prt_idx <= '0;
      end else if (out_free && (prt_idx < count)) begin
        prt_idx <= prt_idx + 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk) begin
    if (out_load) begin
      result_kind <= kind_next;
      char_out    <= char_next;
      last        <= last_next;
    end
  end

  // The list never grows past its capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("list count above capacity");

  // A successful add grows the list by exactly one.
  a_add_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && (op == OP_ADD) && add_ok) |=> (count == $past(count) + 1'b1))
    else $error("add did not grow the list");

  // A get or delete at a bad position reports an invalid position.
  a_bad_pos: assert property (@(posedge clk) disable iff (rst)
    (accept && ((op == OP_GET) || (op == OP_DELETE)) && !rd_ok)
      |=> (out_valid && (result_kind == KIND_INVALID) && last))
    else $error("bad position not reported");

  // Insert and delete are never driven together along the row.
  a_one_shift: assert property (@(posedge clk) disable iff (rst)
    !(ctrl.ins && ctrl.del))
    else $error("insert and delete at once");

endmodule

`default_nettype wire

// ----- hdl/pcl_cell.sv -----
// One storage cell of the list row: holds a byte and takes its left or
// right neighbour's byte when an insert or delete passes over it.
// Depends on pcl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pcl_cell
  import pcl_pkg::*;
(
  input  wire logic              clk,
  input  wire cell_ctrl_t        ctrl,
  input  wire logic [IDX_W-1:0]  cell_idx,
  input  wire logic [CHAR_W-1:0] left_q,
  input  wire logic [CHAR_W-1:0] right_q,
  output logic      [CHAR_W-1:0] q
);

  // Insert moves cells above the slot up by one; delete pulls the cells
  // from the slot onwards down by one.
  always_ff @(posedge clk) begin
    if (ctrl.ins && (cell_idx > ctrl.idx)) begin
      q <= left_q;
    end else if (ctrl.ins && (cell_idx == ctrl.idx)) begin
      q <= ctrl.data;
    end else if (ctrl.del && (cell_idx >= ctrl.idx)) begin
      q <= right_q;
    end
  end

endmodule

`default_nettype wire

// ----- sim/positional_char_list_tb.sv -----
// Self-checking testbench for positional_char_list: a directed table followed by
// state-aware random traffic, checked against a behavioural model of the list.
// Depends on pcl_pkg and the positional_char_list RTL.
`timescale 1ns / 1ps

module positional_char_list_tb;
  import pcl_pkg::*;

  localparam int RANDOM_ITEMS   = 147;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 20;

  // One result as the block should present it on the output channel.
  typedef struct {
    kind_t             kind;
    logic [CHAR_W-1:0] ch;
    logic              last;
  } result_t;

  // One row of the directed table. Where typed is set, the single result is
  // written in by hand and the model's own answer is not used.
  typedef struct {
    op_t               op;
    logic [POS_W-1:0]  pos;
    logic [CHAR_W-1:0] ch;
    bit                typed;
    kind_t             kind;
  } request_row_t;

  // Random traffic moves between phases that fill the list, drain it, and mix.
  typedef enum int {
    TR_GROW,
    TR_SHRINK,
    TR_MIXED
  } traffic_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        opcode = OP_ADD;
  logic [POS_W-1:0]  position = '0;
  logic [CHAR_W-1:0] char_in = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [1:0]        result_kind;
  logic [CHAR_W-1:0] char_out;
  logic              last;

  // Shadow copy of the list contents and its length.
  logic [CHAR_W-1:0] list_bytes [CAPACITY];
  int                list_len = 0;

  // Results the block still owes, oldest first, and the results of the latest
  // transaction as worked out by the model.
  result_t pending_results [$];
  result_t step_results [$];

  int       mismatches = 0;
  bit       in_calm = 1'b0;
  traffic_t traffic = TR_GROW;
  int       phase_items = 0;
  int       boundary_items = 0;

  // Directed table. The list is built up as 00 5A FF A5, read back, printed,
  // and then trimmed at both ends. Invalid positions are tried at zero, just
  // past the end and at the top of the position field.
  request_row_t directed [23] = '{
    '{OP_PRINT,  8'd0,   8'h00, 1'b1, KIND_END},      // print of an empty list
    '{OP_GET,    8'd1,   8'h00, 1'b1, KIND_INVALID},
    '{OP_DELETE, 8'd1,   8'h00, 1'b1, KIND_INVALID},
    '{OP_ADD,    8'd0,   8'h11, 1'b1, KIND_INVALID},
    '{OP_ADD,    8'd2,   8'h22, 1'b1, KIND_INVALID},  // one past count + 1
    '{OP_ADD,    8'd1,   8'hFF, 1'b0, KIND_ELEM},
    '{OP_ADD,    8'd1,   8'h00, 1'b0, KIND_ELEM},     // insert at the front
    '{OP_ADD,    8'd3,   8'hA5, 1'b0, KIND_ELEM},     // append at count + 1
    '{OP_ADD,    8'd2,   8'h5A, 1'b0, KIND_ELEM},     // insert in the middle
    '{OP_ADD,    8'd255, 8'h33, 1'b1, KIND_INVALID},
    '{OP_ADD,    8'd6,   8'h44, 1'b1, KIND_INVALID},
    '{OP_GET,    8'd1,   8'h00, 1'b0, KIND_ELEM},
    '{OP_GET,    8'd4,   8'h00, 1'b0, KIND_ELEM},
    '{OP_GET,    8'd5,   8'h00, 1'b1, KIND_INVALID},
    '{OP_GET,    8'd0,   8'h00, 1'b1, KIND_INVALID},
    '{OP_GET,    8'd128, 8'h00, 1'b1, KIND_INVALID},
    '{OP_DELETE, 8'd0,   8'h00, 1'b1, KIND_INVALID},
    '{OP_DELETE, 8'd5,   8'h00, 1'b1, KIND_INVALID},
    '{OP_PRINT,  8'd0,   8'hFF, 1'b0, KIND_ELEM},
    '{OP_DELETE, 8'd4,   8'h00, 1'b0, KIND_ELEM},     // remove the last entry
    '{OP_DELETE, 8'd1,   8'h00, 1'b0, KIND_ELEM},     // remove the first entry
    '{OP_GET,    8'd2,   8'h00, 1'b0, KIND_ELEM},
    '{OP_PRINT,  8'd7,   8'h00, 1'b0, KIND_ELEM}
  };

  positional_char_list dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .opcode      (opcode),
    .position    (position),
    .char_in     (char_in),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result_kind (result_kind),
    .char_out    (char_out),
    .last        (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Applies one accepted transaction to the shadow list and leaves the results
  // it should cause in step_results. A full list is reported before the
  // position is looked at; a bad position leaves the list untouched.
  function automatic void model_list_op(input op_t op, input logic [POS_W-1:0] pos,
                                        input logic [CHAR_W-1:0] ch);
    int p;
    p = int'(pos);
    step_results = {};
    case (op)
      OP_ADD: begin
        if (list_len >= CAPACITY) begin
          step_results.push_back('{KIND_FULL, '0, 1'b1});
        end else if (p == 0 || p > list_len + 1) begin
          step_results.push_back('{KIND_INVALID, '0, 1'b1});
        end else begin
          for (int i = list_len; i > p - 1; i--) list_bytes[i] = list_bytes[i - 1];
          list_bytes[p - 1] = ch;
          list_len++;
        end
      end
      OP_DELETE: begin
        if (p == 0 || p > list_len) begin
          step_results.push_back('{KIND_INVALID, '0, 1'b1});
        end else begin
          for (int i = p - 1; i + 1 < list_len; i++) list_bytes[i] = list_bytes[i + 1];
          list_len--;
        end
      end
      OP_GET: begin
        if (p == 0 || p > list_len) begin
          step_results.push_back('{KIND_INVALID, '0, 1'b1});
        end else begin
          step_results.push_back('{KIND_ELEM, list_bytes[p - 1], 1'b1});
        end
      end
      default: begin
        for (int i = 0; i < list_len; i++) begin
          step_results.push_back('{KIND_ELEM, list_bytes[i], 1'b0});
        end
        step_results.push_back('{KIND_END, '0, 1'b1});
      end
    endcase
  endfunction

  // Gap before the next request: usually none, sometimes a short one and now
  // and then a long one. During a calm stretch the requests go back to back.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (in_calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Chooses the next random request from the current length of the list, so
  // that most positions are legal and the ends of the list are hit often. A
  // minority of requests carry a position that is out of range.
  function automatic void pick_random_item(output op_t op, output logic [POS_W-1:0] pos,
                                           output logic [CHAR_W-1:0] ch);
    int r;
    int top;
    r = $urandom_range(0, 99);
    case (traffic)
      TR_GROW:   op = (r < 80) ? OP_ADD : (r < 88) ? OP_GET : (r < 94) ? OP_DELETE : OP_PRINT;
      TR_SHRINK: op = (r < 75) ? OP_DELETE : (r < 87) ? OP_GET : (r < 93) ? OP_ADD : OP_PRINT;
      default:   op = (r < 35) ? OP_ADD : (r < 62) ? OP_DELETE : (r < 90) ? OP_GET : OP_PRINT;
    endcase
    top = (op == OP_ADD) ? list_len + 1 : list_len;
    ch = CHAR_W'($urandom_range(0, 255));
    r = $urandom_range(0, 99);
    if (op == OP_PRINT) begin
      pos = POS_W'($urandom_range(0, 255));
    end else if (top == 0 || r < 12) begin
      case ($urandom_range(0, 3))
        0:       pos = '0;
        1:       pos = POS_W'(top + 1);
        2:       pos = POS_W'(255);
        default: pos = POS_W'($urandom_range(0, 255));
      endcase
    end else if (r < 35) begin
      pos = POS_W'(1);
    end else if (r < 58) begin
      pos = POS_W'(top);
    end else begin
      pos = POS_W'($urandom_range(1, top));
    end
  endfunction

  // Presents one request after an optional gap and holds it until the block
  // takes it. Returns at the clock edge on which the transaction completes.
  task automatic send_request(input op_t op, input logic [POS_W-1:0] pos,
                              input logic [CHAR_W-1:0] ch);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    position <= pos;
    char_in  <= ch;
    do @(posedge clk); while (in_stall);
  endtask

  // Request side. The model is stepped at the edge on which each transaction
  // is accepted, before the next request is chosen, so random choices always
  // see the list as the block holds it.
  initial begin : drive_requests
    op_t               op;
    logic [POS_W-1:0]  pos;
    logic [CHAR_W-1:0] ch;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[k]) begin
      send_request(directed[k].op, directed[k].pos, directed[k].ch);
      model_list_op(directed[k].op, directed[k].pos, directed[k].ch);
      if (directed[k].typed) begin
        pending_results.push_back('{directed[k].kind, '0, 1'b1});
      end else begin
        foreach (step_results[j]) pending_results.push_back(step_results[j]);
      end
    end

    // Random part: fill the list until adds report it full, drain it until
    // deletes find it empty, mix for a while, and go round again.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick_random_item(op, pos, ch);
      send_request(op, pos, ch);
      model_list_op(op, pos, ch);
      foreach (step_results[j]) pending_results.push_back(step_results[j]);

      phase_items++;
      if ((traffic == TR_GROW && list_len == CAPACITY) ||
          (traffic == TR_SHRINK && list_len == 0)) begin
        boundary_items++;
      end
      if ((traffic == TR_GROW && boundary_items > 4) ||
          (traffic == TR_SHRINK && boundary_items > 2) ||
          (traffic == TR_MIXED && phase_items > 25)) begin
        traffic = (traffic == TR_GROW) ? TR_SHRINK : (traffic == TR_SHRINK) ? TR_MIXED : TR_GROW;
        phase_items = 0;
        boundary_items = 0;
      end
      if (n % 30 == 29) in_calm = ($urandom_range(0, 3) == 0);
    end
    in_valid <= 1'b0;

    // Let every owed result arrive, then watch a little longer for strays.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Result side: each accepted transaction is compared with the oldest owed
  // result. The stall line alternates between runs of random length, mostly
  // short, with occasional long stalls and long stretches of no stall at all.
  always @(posedge clk) begin : check_results
    result_t want;
    int      r;
    int      stall_left;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: result_kind %0d char_out 'h%02h last %0b",
               result_kind, char_out, last);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (result_kind !== want.kind) begin
          $error("result_kind: expected %0d, got %0d", want.kind, result_kind);
          mismatches++;
        end
        if (char_out !== want.ch) begin
          $error("char_out: expected 'h%02h, got 'h%02h", want.ch, char_out);
          mismatches++;
        end
        if (last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, last);
          mismatches++;
        end
      end
    end

    if (stall_left <= 0) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        out_stall <= 1'b0;
        stall_left = $urandom_range(1, 6);
      end else if (r < 85) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(1, 3);
      end else if (r < 93) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(8, 40);
      end else begin
        out_stall <= 1'b0;
        stall_left = $urandom_range(30, 80);
      end
    end else begin
      stall_left--;
    end
  end

  // Watchdog: the run is abandoned once neither channel has completed a
  // transaction for a long time. The longest legitimate quiet spell is a long
  // request gap or a long output stall, both far below the limit.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/pcl_pkg.sv
hdl/pcl_cell.sv
hdl/positional_char_list.sv
sim/positional_char_list_tb.sv
